### rtl/scp_pkg.sv
`default_nettype none
package scp_pkg;

	localparam int unsigned COORD_W     = 32;
	localparam int unsigned DIFF_W      = 33;
	localparam int unsigned KC_W        = 33;
	localparam int unsigned MUL_W       = 34;
	localparam int unsigned ACC_W       = 64;
	localparam int unsigned CRMAG_W     = 62;
	localparam int unsigned SUM_W       = 34;
	localparam int unsigned SHAMT_W     = 6;

	localparam int unsigned SQRT_RAD_W  = 64;
	localparam int unsigned SQRT_ROOT_W = 32;
	localparam int unsigned SQRT_CNT_W  = 5;

	localparam int unsigned DIV_NUM_W   = 96;
	localparam int unsigned DIV_DEN_W   = 63;
	localparam int unsigned DIV_QUO_W   = 34;
	localparam int unsigned DIV_CNT_W   = 7;

	// 10 + (left shifts) - (right shifts)
	localparam logic [SHAMT_W-1:0] SHAMT_INIT = 6'd10;
	// ceil(2^34 / 3), exact for magnitudes below 2^33
	localparam logic [MUL_W-1:0]   RECIP3     = 34'h155555556;
	localparam logic [DIV_QUO_W-1:0] POS_LIM  = 34'h07FFFFFFF;
	localparam logic [DIV_QUO_W-1:0] NEG_LIM  = 34'h080000000;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_DIFF,
		ST_NORM,
		ST_FIX,
		ST_SQ1,
		ST_SQ2,
		ST_SQ_GO,
		ST_SQ_WAIT,
		ST_CR1,
		ST_CR2,
		ST_CR3,
		ST_AB,
		ST_Q1_GO,
		ST_Q1_WAIT,
		ST_Q2_GO,
		ST_Q2_WAIT,
		ST_CALC,
		ST_EMUL,
		ST_EPUT
	} state_t;

	typedef enum logic [1:0] {
		SIDE_A,
		SIDE_B,
		SIDE_C
	} side_t;

endpackage
`default_nettype wire

### rtl/scp_if.sv
`default_nettype none
interface scp_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] x_coord;
	logic signed [31:0] y_coord;
	logic               path_end;

	modport source (output valid, output x_coord, output y_coord, output path_end, input ready);
	modport sink   (input valid, input x_coord, input y_coord, input path_end, output ready);
endinterface

interface scp_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] curvature;
	logic               degenerate;
	logic               final_result;

	modport source (output valid, output curvature, output degenerate, output final_result,
		input ready);
	modport sink   (input valid, input curvature, input degenerate, input final_result,
		output ready);
endinterface
`default_nettype wire

### rtl/scp_sqrt.sv
`default_nettype none
module scp_sqrt import scp_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	input  wire logic [SQRT_RAD_W-1:0]  rad,
	output logic      [SQRT_ROOT_W-1:0] root,
	output logic                        done
);

	logic                   busy_q;
	logic                   done_q;
	logic [SQRT_CNT_W-1:0]  cnt_q;
	logic [SQRT_RAD_W-1:0]  rad_q;
	logic [SQRT_ROOT_W:0]   rem_q;
	logic [SQRT_ROOT_W-1:0] root_q;
	logic [SQRT_ROOT_W+2:0] r4;
	logic [SQRT_ROOT_W+2:0] trial;
	logic                   ge;

	assign r4    = {rem_q, rad_q[SQRT_RAD_W-1 -: 2]};
	assign trial = {1'b0, root_q, 2'b01};
	assign ge    = (r4 >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= SQRT_CNT_W'(SQRT_ROOT_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= rad;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= rad_q << 2;
			rem_q  <= ge ? (SQRT_ROOT_W+1)'(r4 - trial) : r4[SQRT_ROOT_W:0];
			root_q <= {root_q[SQRT_ROOT_W-2:0], ge};
		end
	end

	assign root = root_q;
	assign done = done_q;

endmodule
`default_nettype wire

### rtl/scp_div.sv
`default_nettype none
module scp_div import scp_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic [DIV_NUM_W-1:0] num,
	input  wire logic [DIV_DEN_W-1:0] den,
	output logic      [DIV_QUO_W-1:0] quo,
	output logic                      ovf,
	output logic                      done
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_NUM_W-1:0] num_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_QUO_W-1:0] quo_q;
	logic                 ovf_q;
	logic [DIV_DEN_W:0]   r2;
	logic                 ge;

	assign r2 = {rem_q, num_q[DIV_NUM_W-1]};
	assign ge = (r2 >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_NUM_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// quotient bits falling off the top of the window only mark overflow
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
			quo_q <= '0;
			ovf_q <= 1'b0;
		end else if (busy_q) begin
			num_q <= num_q << 1;
			rem_q <= ge ? DIV_DEN_W'(r2 - {1'b0, den_q}) : r2[DIV_DEN_W-1:0];
			quo_q <= {quo_q[DIV_QUO_W-2:0], ge};
			ovf_q <= ovf_q | quo_q[DIV_QUO_W-1];
		end
	end

	assign quo  = quo_q;
	assign ovf  = ovf_q;
	assign done = done_q;

endmodule
`default_nettype wire

### rtl/smoothed_three_point_curvature.sv
`default_nettype none
// Streams path points (Q16.16) and returns one smoothed signed curvature (Q8.24, saturated)
// per point, two points late; the point marked last flushes the remaining two results, and
// a path of one or two points gives zeros. Not ready while an item is in work: an interior
// point passes through normalising shifts, the shared square-root unit (three 32-step roots,
// one per side), one shared 34x34 multiplier and the shared bit-serial divider (two 96-step
// divisions) before its mean; a point that closes a degenerate triangle skips the roots and
// divisions. Each result is held in the output register while the output stalls.
module smoothed_three_point_curvature import scp_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	scp_in_if.sink    point,
	scp_out_if.source result
);

	state_t state_q, state_d;

	logic signed [COORD_W-1:0] px_old_q, py_old_q, px_rec_q, py_rec_q;
	logic [KC_W-1:0]           kc_old_q, kc_rec_q;
	logic [1:0]                seen_q;

	logic signed [COORD_W-1:0] xin_q, yin_q;
	logic                      last_q;

	logic [DIFF_W-1:0]         ma_x_q, ma_y_q, mb_x_q, mb_y_q;
	logic [3:0]                sgn_q;
	logic [SHAMT_W-1:0]        shamt_q;
	logic signed [COORD_W-1:0] ax_q, ay_q, bx_q, by_q, cx_q, cy_q;
	side_t                     side_q;
	logic [SQRT_ROOT_W-1:0]    a_q, b_q, c_q;

	logic signed [MUL_W-1:0]   mul_a, mul_b;
	logic signed [2*MUL_W-1:0] p_q;
	logic [ACC_W-1:0]          acc_q;

	logic                      neg_q;
	logic [CRMAG_W-1:0]        crmag_q;
	logic [DIV_QUO_W-1:0]      q1_q;
	logic [KC_W-1:0]           nw_q;

	logic [KC_W-1:0]           k0_q, k1_q, k2_q;
	logic [1:0]                em_n_q, em_j_q;
	logic                      sum_neg_q;

	logic                      out_valid_q;
	logic signed [31:0]        out_curv_q;
	logic                      out_deg_q, out_fin_q;

	// differences and degeneracy
	logic signed [DIFF_W-1:0]  dax, day, dbx, dby;
	logic                      deg;
	assign dax = DIFF_W'(px_rec_q) - DIFF_W'(px_old_q);
	assign day = DIFF_W'(py_rec_q) - DIFF_W'(py_old_q);
	assign dbx = DIFF_W'(xin_q) - DIFF_W'(px_rec_q);
	assign dby = DIFF_W'(yin_q) - DIFF_W'(py_rec_q);
	assign deg = (dax == '0 && day == '0) || (dbx == '0 && dby == '0) ||
		(px_old_q == xin_q && py_old_q == yin_q);

	function automatic logic [DIFF_W-1:0] mag33(input logic signed [DIFF_W-1:0] v);
		return v[DIFF_W-1] ? DIFF_W'(-v) : DIFF_W'(v);
	endfunction

	function automatic logic signed [COORD_W-1:0] apply_sign(input logic [DIFF_W-1:0] m,
		input logic s);
		return s ? -$signed(m[COORD_W-1:0]) : $signed(m[COORD_W-1:0]);
	endfunction

	function automatic logic signed [MUL_W-1:0] sx(input logic signed [COORD_W-1:0] v);
		return {{(MUL_W-COORD_W){v[COORD_W-1]}}, v};
	endfunction

	function automatic logic signed [SUM_W-1:0] sk(input logic [KC_W-1:0] k);
		return {{(SUM_W-32){k[31]}}, k[31:0]};
	endfunction

	logic norm_big, norm_small;
	assign norm_big   = |{ma_x_q[32:30], ma_y_q[32:30], mb_x_q[32:30], mb_y_q[32:30]};
	assign norm_small = ~|{ma_x_q[32:29], ma_y_q[32:29], mb_x_q[32:29], mb_y_q[32:29]};

	logic signed [COORD_W-1:0] ax_f, ay_f, bx_f, by_f;
	assign ax_f = apply_sign(ma_x_q, sgn_q[0]);
	assign ay_f = apply_sign(ma_y_q, sgn_q[1]);
	assign bx_f = apply_sign(mb_x_q, sgn_q[2]);
	assign by_f = apply_sign(mb_y_q, sgn_q[3]);

	logic signed [ACC_W-1:0] cr;
	logic [ACC_W-1:0]        cr_mag;
	assign cr     = $signed(acc_q) - $signed(p_q[ACC_W-1:0]);
	assign cr_mag = cr[ACC_W-1] ? ACC_W'(-cr) : ACC_W'(cr);

	// shared units
	logic                   sq_start, sq_done;
	logic [SQRT_RAD_W-1:0]  sq_rad;
	logic [SQRT_ROOT_W-1:0] sq_root;
	logic                   dv_start, dv_done, dv_ovf;
	logic [DIV_NUM_W-1:0]   dv_num;
	logic [DIV_DEN_W-1:0]   dv_den;
	logic [DIV_QUO_W-1:0]   dv_quo;

	assign sq_rad = acc_q + p_q[ACC_W-1:0];

	scp_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.rad    (sq_rad),
		.root   (sq_root),
		.done   (sq_done)
	);

	scp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dv_start),
		.num    (dv_num),
		.den    (dv_den),
		.quo    (dv_quo),
		.ovf    (dv_ovf),
		.done   (dv_done)
	);

	// saturation of the final quotient
	logic [DIV_QUO_W-1:0]  lim, sat_mag;
	logic [KC_W-1:0]       nw_sat;
	assign lim     = neg_q ? NEG_LIM : POS_LIM;
	assign sat_mag = (dv_ovf || dv_quo > lim) ? lim : dv_quo;
	assign nw_sat  = {1'b0, neg_q ? 32'(-sat_mag[31:0]) : sat_mag[31:0]};

	logic [KC_W-1:0] ko_e, kr_e;
	assign ko_e = (seen_q == 2'd2) ? nw_q : kc_old_q;
	assign kr_e = (seen_q == 2'd2) ? nw_q : kc_rec_q;

	// three-tap mean
	logic signed [SUM_W-1:0] sum;
	logic                    sum_flag;
	logic [SUM_W-1:0]        sum_mag;
	always_comb begin
		if (em_j_q == 2'd0) begin
			sum      = sk(k0_q) + sk(k1_q) + sk(k2_q);
			sum_flag = k0_q[32] | k1_q[32] | k2_q[32];
		end else if (em_j_q == 2'd1) begin
			sum      = sk(k1_q) + sk(k2_q) + sk(k2_q);
			sum_flag = k1_q[32] | k2_q[32];
		end else begin
			sum      = sk(k2_q) + sk(k2_q) + sk(k2_q);
			sum_flag = k2_q[32];
		end
	end
	assign sum_mag = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);

	logic [31:0] mean_q;
	logic        em_last, out_free;
	assign mean_q   = p_q[65:34];
	assign em_last  = (2'(em_j_q + 2'd1) == em_n_q);
	assign out_free = !out_valid_q || result.ready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:    if (point.valid) state_d = ST_DIFF;
			ST_DIFF: begin
				if (seen_q < 2'd2) state_d = last_q ? ST_EMUL : ST_IDLE;
				else if (deg)      state_d = ST_CALC;
				else               state_d = ST_NORM;
			end
			ST_NORM:    if (!norm_big && !norm_small) state_d = ST_FIX;
			ST_FIX:     state_d = ST_SQ1;
			ST_SQ1:     state_d = ST_SQ2;
			ST_SQ2:     state_d = ST_SQ_GO;
			ST_SQ_GO:   state_d = ST_SQ_WAIT;
			ST_SQ_WAIT: begin
				if (sq_done) begin
					if (side_q != SIDE_C)                           state_d = ST_SQ1;
					else if (a_q == '0 || b_q == '0 || sq_root == '0) state_d = ST_CALC;
					else                                            state_d = ST_CR1;
				end
			end
			ST_CR1:     state_d = ST_CR2;
			ST_CR2:     state_d = ST_CR3;
			ST_CR3:     state_d = (cr == '0) ? ST_CALC : ST_AB;
			ST_AB:      state_d = ST_Q1_GO;
			ST_Q1_GO:   state_d = ST_Q1_WAIT;
			ST_Q1_WAIT: if (dv_done) state_d = ST_Q2_GO;
			ST_Q2_GO:   state_d = ST_Q2_WAIT;
			ST_Q2_WAIT: if (dv_done) state_d = ST_CALC;
			ST_CALC:    state_d = ST_EMUL;
			ST_EMUL:    state_d = ST_EPUT;
			ST_EPUT:    if (out_free) state_d = em_last ? ST_IDLE : ST_EMUL;
			default:    state_d = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		point.ready = 1'b0;
		sq_start    = 1'b0;
		dv_start    = 1'b0;
		mul_a       = '0;
		mul_b       = '0;
		dv_num      = '0;
		dv_den      = '0;
		unique case (state_q)
			ST_IDLE:  point.ready = 1'b1;
			ST_SQ1: begin
				unique case (side_q)
					SIDE_A:  begin mul_a = sx(ax_q); mul_b = sx(ax_q); end
					SIDE_B:  begin mul_a = sx(bx_q); mul_b = sx(bx_q); end
					default: begin mul_a = sx(cx_q); mul_b = sx(cx_q); end
				endcase
			end
			ST_SQ2: begin
				unique case (side_q)
					SIDE_A:  begin mul_a = sx(ay_q); mul_b = sx(ay_q); end
					SIDE_B:  begin mul_a = sx(by_q); mul_b = sx(by_q); end
					default: begin mul_a = sx(cy_q); mul_b = sx(cy_q); end
				endcase
			end
			ST_SQ_GO: sq_start = 1'b1;
			ST_CR1:   begin mul_a = sx(ax_q); mul_b = sx(by_q); end
			ST_CR2:   begin mul_a = sx(ay_q); mul_b = sx(bx_q); end
			ST_AB:    begin mul_a = {2'b00, a_q}; mul_b = {2'b00, b_q}; end
			ST_Q1_GO: begin
				dv_start = 1'b1;
				dv_num   = {3'b000, crmag_q, 31'd0};
				dv_den   = p_q[DIV_DEN_W-1:0];
			end
			ST_Q2_GO: begin
				dv_start = 1'b1;
				dv_num   = {(DIV_NUM_W-DIV_QUO_W)'(0), q1_q} << shamt_q;
				dv_den   = {(DIV_DEN_W-SQRT_ROOT_W)'(0), c_q};
			end
			// mean held in the product register while the output stalls
			ST_EMUL, ST_EPUT: begin mul_a = $signed(sum_mag); mul_b = $signed(RECIP3); end
			default:  ;
		endcase
	end

	// sequencer and path state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			px_old_q    <= '0;
			py_old_q    <= '0;
			px_rec_q    <= '0;
			py_rec_q    <= '0;
			kc_old_q    <= '0;
			kc_rec_q    <= '0;
			seen_q      <= '0;
			em_n_q      <= '0;
			em_j_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_EPUT && out_free) out_valid_q <= 1'b1;
			else if (result.ready)              out_valid_q <= 1'b0;
			unique case (state_q)
				ST_DIFF: begin
					if (seen_q < 2'd2) begin
						em_j_q <= '0;
						em_n_q <= 2'(seen_q + 2'd1);
						if (last_q) begin
							px_old_q <= '0;
							py_old_q <= '0;
							px_rec_q <= '0;
							py_rec_q <= '0;
							seen_q   <= '0;
						end else begin
							px_old_q <= px_rec_q;
							py_old_q <= py_rec_q;
							px_rec_q <= xin_q;
							py_rec_q <= yin_q;
							seen_q   <= 2'(seen_q + 2'd1);
						end
					end
				end
				ST_CALC: begin
					em_j_q <= '0;
					em_n_q <= last_q ? 2'd3 : 2'd1;
					if (last_q) begin
						px_old_q <= '0;
						py_old_q <= '0;
						px_rec_q <= '0;
						py_rec_q <= '0;
						kc_old_q <= '0;
						kc_rec_q <= '0;
						seen_q   <= '0;
					end else begin
						kc_old_q <= kr_e;
						kc_rec_q <= nw_q;
						px_old_q <= px_rec_q;
						py_old_q <= py_rec_q;
						px_rec_q <= xin_q;
						py_rec_q <= yin_q;
						seen_q   <= 2'd3;
					end
				end
				ST_EPUT: begin
					if (out_free) begin
						em_j_q <= 2'(em_j_q + 2'd1);
					end
				end
				default: ;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		p_q <= mul_a * mul_b;
		unique case (state_q)
			ST_IDLE: begin
				xin_q  <= point.x_coord;
				yin_q  <= point.y_coord;
				last_q <= point.path_end;
			end
			ST_DIFF: begin
				ma_x_q  <= mag33(dax);
				ma_y_q  <= mag33(day);
				mb_x_q  <= mag33(dbx);
				mb_y_q  <= mag33(dby);
				sgn_q   <= {dby[DIFF_W-1], dbx[DIFF_W-1], day[DIFF_W-1], dax[DIFF_W-1]};
				shamt_q <= SHAMT_INIT;
				nw_q    <= {1'b1, 32'd0};
				k0_q    <= '0;
				k1_q    <= '0;
				k2_q    <= '0;
			end
			ST_NORM: begin
				if (norm_big) begin
					ma_x_q  <= ma_x_q >> 1;
					ma_y_q  <= ma_y_q >> 1;
					mb_x_q  <= mb_x_q >> 1;
					mb_y_q  <= mb_y_q >> 1;
					shamt_q <= shamt_q - 1'b1;
				end else if (norm_small) begin
					ma_x_q  <= ma_x_q << 1;
					ma_y_q  <= ma_y_q << 1;
					mb_x_q  <= mb_x_q << 1;
					mb_y_q  <= mb_y_q << 1;
					shamt_q <= shamt_q + 1'b1;
				end
			end
			ST_FIX: begin
				ax_q   <= ax_f;
				ay_q   <= ay_f;
				bx_q   <= bx_f;
				by_q   <= by_f;
				cx_q   <= -(ax_f + bx_f);
				cy_q   <= -(ay_f + by_f);
				side_q <= SIDE_A;
			end
			ST_SQ2:  acc_q <= p_q[ACC_W-1:0];
			ST_SQ_WAIT: begin
				if (sq_done) begin
					unique case (side_q)
						SIDE_A:  begin a_q <= sq_root; side_q <= SIDE_B; end
						SIDE_B:  begin b_q <= sq_root; side_q <= SIDE_C; end
						default: c_q <= sq_root;
					endcase
					nw_q <= '0;
				end
			end
			ST_CR2:  acc_q <= p_q[ACC_W-1:0];
			ST_CR3: begin
				neg_q   <= cr[ACC_W-1];
				crmag_q <= cr_mag[CRMAG_W-1:0];
				nw_q    <= '0;
			end
			ST_Q1_WAIT: if (dv_done) q1_q <= dv_quo;
			ST_Q2_WAIT: if (dv_done) nw_q <= nw_sat;
			ST_CALC: begin
				k0_q <= ko_e;
				k1_q <= kr_e;
				k2_q <= nw_q;
			end
			ST_EMUL: sum_neg_q <= sum[SUM_W-1];
			ST_EPUT: begin
				if (out_free) begin
					out_curv_q <= sum_neg_q ? -$signed(mean_q) : $signed(mean_q);
					out_deg_q  <= sum_flag;
					out_fin_q  <= last_q && em_last;
				end
			end
			default: ;
		endcase
	end

	assign result.valid        = out_valid_q;
	assign result.curvature    = out_curv_q;
	assign result.degenerate   = out_deg_q;
	assign result.final_result = out_fin_q;

`ifndef SYNTH
	a_accept_to_diff: assert property (@(posedge clk) disable iff (!arst_n)
		point.valid && point.ready |=> state_q == ST_DIFF)
		else $error("accepted request not taken into work");

	a_sqrt_done_owned: assert property (@(posedge clk) disable iff (!arst_n)
		sq_done |-> state_q == ST_SQ_WAIT)
		else $error("square root finished outside its wait");

	a_div_done_owned: assert property (@(posedge clk) disable iff (!arst_n)
		dv_done |-> (state_q == ST_Q1_WAIT || state_q == ST_Q2_WAIT))
		else $error("division finished outside its wait");

	a_shamt_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_Q2_GO |-> (shamt_q >= 6'd7 && shamt_q <= 6'd39))
		else $error("scale shift out of range");

	a_final_needs_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) && out_fin_q |-> last_q)
		else $error("final result without last point");
`endif

endmodule
`default_nettype wire

### dv/tb.sv
`default_nettype none
module tb;
	import scp_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned IDLE_LIMIT = 6000;
	localparam int unsigned HOLD_CYCLES = 700;

	typedef struct {
		logic signed [31:0] curvature;
		logic               degenerate;
		logic               final_result;
	} curv_result_t;

	logic clk;
	logic arst_n;

	scp_in_if  point_ch();
	scp_out_if result_ch();

	smoothed_three_point_curvature dut (
		.clk    (clk),
		.arst_n (arst_n),
		.point  (point_ch.sink),
		.result (result_ch.source)
	);

	curv_result_t pending_curvs[$];
	int unsigned  errors;
	int unsigned  idle_cycles;
	bit           quiet;
	int unsigned  hold_len;

	// predictor state
	longint       old_x, old_y, rec_x, rec_y;
	logic [32:0]  kc_old, kc_rec;
	int unsigned  pts_seen;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint unsigned root64(longint unsigned n);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic longint unsigned magn(longint v);
		return v < 0 ? longint'(0) - v : v;
	endfunction

	function automatic longint rescale(longint v, int l, int r);
		longint unsigned m;
		m = (magn(v) << l) >> r;
		return v < 0 ? -longint'(m) : longint'(m);
	endfunction

	// bits 31..0 curvature, bit 32 zero-side flag
	function automatic logic [32:0] triangle_curv(longint x0, longint y0, longint x1,
		longint y1, longint x2, longint y2);
		longint          ax, ay, bx, by, cx, cy, cr;
		longint unsigned m, a, b, c, lim;
		logic [127:0]    num, q;
		int              l, r;
		bit              neg;
		ax = x1 - x0; ay = y1 - y0; bx = x2 - x1; by = y2 - y1;
		if ((ax == 0 && ay == 0) || (bx == 0 && by == 0) || (x0 == x2 && y0 == y2))
			return 33'h1_0000_0000;
		m = magn(ax);
		if (magn(ay) > m) m = magn(ay);
		if (magn(bx) > m) m = magn(bx);
		if (magn(by) > m) m = magn(by);
		r = 0;
		l = 0;
		while ((m >> r) >= (64'd1 << 30)) r++;
		while ((m << l) < (64'd1 << 29)) l++;
		ax = rescale(ax, l, r); ay = rescale(ay, l, r);
		bx = rescale(bx, l, r); by = rescale(by, l, r);
		cx = -(ax + bx); cy = -(ay + by);
		a = root64(longint'(ax * ax) + longint'(ay * ay));
		b = root64(longint'(bx * bx) + longint'(by * by));
		c = root64(longint'(cx * cx) + longint'(cy * cy));
		if (a == 0 || b == 0 || c == 0) return '0;
		cr = ax * by - ay * bx;
		if (cr == 0) return '0;
		neg = cr < 0;
		num = 128'(magn(cr)) << 31;
		q = num / 128'(a * b);
		num = q << (10 + l - r);
		q = num / 128'(c);
		lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
		if (q > 128'(lim)) q = 128'(lim);
		return neg ? {1'b0, 32'(32'd0 - q[31:0])} : {1'b0, q[31:0]};
	endfunction

	function automatic void push_curv(longint sum, logic flag, logic last);
		curv_result_t e;
		e.curvature    = 32'(sum / 3);
		e.degenerate   = flag;
		e.final_result = last;
		pending_curvs.insert(pending_curvs.size(), e);
	endfunction

	function automatic void clear_path();
		old_x = 0; old_y = 0; rec_x = 0; rec_y = 0;
		kc_old = '0; kc_rec = '0;
		pts_seen = 0;
	endfunction

	function automatic void predict_point(longint x, longint y, logic last);
		logic [32:0] nw;
		longint      ko, kr, kn;
		if (pts_seen < 2) begin
			if (last) begin
				for (int k = 0; k <= int'(pts_seen); k++) push_curv(0, 1'b0, k == pts_seen);
				clear_path();
				return;
			end
			old_x = rec_x; old_y = rec_y;
			rec_x = x; rec_y = y;
			pts_seen++;
			return;
		end
		nw = triangle_curv(old_x, old_y, rec_x, rec_y, x, y);
		if (pts_seen == 2) begin
			kc_old = nw;
			kc_rec = nw;
		end
		ko = longint'($signed(kc_old[31:0]));
		kr = longint'($signed(kc_rec[31:0]));
		kn = longint'($signed(nw[31:0]));
		push_curv(ko + kr + kn, kc_old[32] | kc_rec[32] | nw[32], 1'b0);
		if (last) begin
			push_curv(kr + kn + kn, kc_rec[32] | nw[32], 1'b0);
			push_curv(kn * 3, nw[32], 1'b1);
			clear_path();
			return;
		end
		kc_old = kc_rec;
		kc_rec = nw;
		old_x = rec_x; old_y = rec_y;
		rec_x = x; rec_y = y;
		pts_seen = 3;
	endfunction

	task automatic send_point(logic [31:0] x, logic [31:0] y, logic last);
		int unsigned gap;
		gap = quiet ? 0 : $urandom_range(0, 7);
		if (gap != 0) begin
			point_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		point_ch.valid    <= 1'b1;
		point_ch.x_coord  <= x;
		point_ch.y_coord  <= y;
		point_ch.path_end <= last;
		do @(posedge clk); while (!point_ch.ready);
		predict_point(longint'($signed(x)), longint'($signed(y)), last);
	endtask

	task automatic drain();
		point_ch.valid <= 1'b0;
		while (pending_curvs.size() != 0) @(posedge clk);
	endtask

	task automatic test_short_paths();
		send_point(32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
		send_point(32'h0001_0000, 32'h0002_0000, 1'b0);
		send_point(32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
	endtask

	task automatic test_triangles();
		// left turn, then right turn, then straight
		send_point(32'h0000_0000, 32'h0000_0000, 1'b0);
		send_point(32'h0001_0000, 32'h0000_0000, 1'b0);
		send_point(32'h0001_0000, 32'h0001_0000, 1'b0);
		send_point(32'h0002_0000, 32'h0001_0000, 1'b0);
		send_point(32'h0003_0000, 32'h0001_0000, 1'b1);
		// tiny sharp turn saturates
		send_point(32'h0000_0000, 32'h0000_0000, 1'b0);
		send_point(32'h0000_0001, 32'h0000_0000, 1'b0);
		send_point(32'h0000_0000, 32'h0000_0001, 1'b0);
		send_point(32'h0000_0001, 32'h0000_0001, 1'b1);
		drain();
	endtask

	task automatic test_degenerate();
		// repeated point, then back-tracking, then extremes
		send_point(32'h0010_0000, 32'h0020_0000, 1'b0);
		send_point(32'h0010_0000, 32'h0020_0000, 1'b0);
		send_point(32'h0030_0000, 32'h0020_0000, 1'b0);
		send_point(32'h0010_0000, 32'h0020_0000, 1'b0);
		send_point(32'h0010_0000, 32'h0020_0000, 1'b1);
		send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
		send_point(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
		send_point(32'h8000_0000, 32'h8000_0000, 1'b0);
		send_point(32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
		drain();
	endtask

	task automatic send_random_path(int unsigned len);
		logic [31:0] bx, by, x, y;
		int unsigned mode, spread;
		bx = $urandom(); by = $urandom();
		mode = $urandom_range(0, 9);
		spread = (mode < 3) ? 2000 : (mode < 6) ? (1 << 20) : (1 << 28);
		for (int i = 0; i < int'(len); i++) begin
			if (mode == 9 || $urandom_range(0, 19) == 0) begin
				x = $urandom(); y = $urandom();
			end else if ($urandom_range(0, 11) == 0) begin
				x = bx; y = by;
			end else begin
				x = bx + 32'($urandom_range(0, spread)) - 32'(spread / 2);
				y = by + 32'($urandom_range(0, spread)) - 32'(spread / 2);
			end
			send_point(x, y, i == int'(len) - 1);
			bx = x; by = y;
		end
	endtask

	task automatic test_random_paths();
		int unsigned sent, len;
		sent = 0;
		while (sent < 345) begin
			len = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 14);
			quiet = $urandom_range(0, 5) == 0;
			send_random_path(len);
			sent += len;
		end
		quiet = 1'b0;
	endtask

	task automatic test_backpressure();
		hold_len = HOLD_CYCLES;
		send_random_path(10);
		drain();
	endtask

	// receiver
	initial begin
		result_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			int unsigned stall;
			if (hold_len != 0) begin
				result_ch.ready <= 1'b0;
				repeat (hold_len) @(posedge clk);
				hold_len = 0;
			end
			stall = quiet ? 0 : $urandom_range(0, 7);
			if (stall != 0) begin
				result_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (!(result_ch.valid && result_ch.ready));
		end
	end

	// result checker
	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pending_curvs.size() == 0) begin
				$error("unexpected result: curvature %0d", result_ch.curvature);
				errors++;
			end else begin
				curv_result_t e;
				e = pending_curvs.pop_front();
				if (result_ch.curvature !== e.curvature) begin
					$error("curvature: expected %0d, got %0d", e.curvature, result_ch.curvature);
					errors++;
				end
				if (result_ch.degenerate !== e.degenerate) begin
					$error("degenerate: expected %0b, got %0b", e.degenerate,
						result_ch.degenerate);
					errors++;
				end
				if (result_ch.final_result !== e.final_result) begin
					$error("final_result: expected %0b, got %0b", e.final_result,
						result_ch.final_result);
					errors++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((point_ch.valid && point_ch.ready) || (result_ch.valid && result_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		errors = 0;
		idle_cycles = 0;
		quiet = 1'b0;
		hold_len = 0;
		clear_path();
		arst_n            <= 1'b0;
		point_ch.valid    <= 1'b0;
		point_ch.x_coord  <= '0;
		point_ch.y_coord  <= '0;
		point_ch.path_end <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_short_paths();
		test_triangles();
		test_degenerate();
		test_backpressure();
		test_random_paths();
		drain();
		repeat (20) @(posedge clk);
		if (errors == 0 && pending_curvs.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end
endmodule
`default_nettype wire
